// ===== rtl/pfc_pkg.sv =====
// ----------------------------------------------------------------------------
// pfc_pkg: shared types and constants of the pixel format converter
// Format codes, configuration register indexes, luma weights and widths.
// ----------------------------------------------------------------------------
package pfc_pkg;

  typedef logic [7:0] byte_t;

  // Pixel layouts; code 7 is unused and handled by default arms
  typedef enum logic [2:0] {
    FMT_R    = 3'd0,
    FMT_RA   = 3'd1,
    FMT_RG   = 3'd2,
    FMT_RGB  = 3'd3,
    FMT_RGBA = 3'd4,
    FMT_BGR  = 3'd5,
    FMT_BGRA = 3'd6
  } fmt_e;

  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 8;
  localparam int unsigned FmtW     = 3;
  localparam int unsigned CountW   = 3;

  typedef logic [CfgIdxW-1:0]  cfg_idx_t;
  typedef logic [CfgDataW-1:0] cfg_data_t;
  typedef logic [FmtW-1:0]     fmt_t;
  typedef logic [CountW-1:0]   count_t;

  localparam cfg_idx_t CfgIdxSrc = cfg_idx_t'(0);
  localparam cfg_idx_t CfgIdxTgt = cfg_idx_t'(1);

  localparam fmt_t FmtReset = FMT_RGBA;

  // BT.601 luma weights in Q16, summing to 65536
  localparam int unsigned ProdW = 24;
  typedef logic [ProdW-1:0] prod_t;
  localparam prod_t LumaWr = prod_t'(19595);
  localparam prod_t LumaWg = prod_t'(38470);
  localparam prod_t LumaWb = prod_t'(7471);

  localparam byte_t AlphaOpaque = 8'hFF;

endpackage

// ===== rtl/pfc_pix_in_if.sv =====
// ----------------------------------------------------------------------------
// pfc_pix_in_if: source pixel channel
// Valid/ready channel carrying up to four raw bytes of one pixel.
// ----------------------------------------------------------------------------
interface pfc_pix_in_if import pfc_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t first_byte;
  byte_t second_byte;
  byte_t third_byte;
  byte_t fourth_byte;

  modport source (
    output valid, first_byte, second_byte, third_byte, fourth_byte,
    input  ready
  );
  modport sink (
    input  valid, first_byte, second_byte, third_byte, fourth_byte,
    output ready
  );
endinterface

// ===== rtl/pfc_pix_out_if.sv =====
// ----------------------------------------------------------------------------
// pfc_pix_out_if: converted pixel channel
// Valid/ready channel carrying four output bytes and a byte count.
// ----------------------------------------------------------------------------
interface pfc_pix_out_if import pfc_pkg::*; ();
  logic   valid;
  logic   ready;
  byte_t  out_byte0;
  byte_t  out_byte1;
  byte_t  out_byte2;
  byte_t  out_byte3;
  count_t byte_count;

  modport source (
    output valid, out_byte0, out_byte1, out_byte2, out_byte3, byte_count,
    input  ready
  );
  modport sink (
    input  valid, out_byte0, out_byte1, out_byte2, out_byte3, byte_count,
    output ready
  );
endinterface

// ===== rtl/pfc_cfg_if.sv =====
// ----------------------------------------------------------------------------
// pfc_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface pfc_cfg_if import pfc_pkg::*; ();
  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;

  modport source (
    output valid, index, data,
    input  ready
  );
  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

// ===== rtl/pixel_format_converter_core.sv =====
// ----------------------------------------------------------------------------
// pixel_format_converter_core: 8-bit RGB pixel format converter
// Unpacks a pixel in the source layout, computes BT.601 luma and repacks
// it in the target layout, one pixel per clock while pix_out_o does not stall, through a 4-stage pipeline.
// ----------------------------------------------------------------------------
//
//  Channel    Modport  Role                               Transaction
//  ---------  -------  ---------------------------------  ---------------------
//  pix_in_i   sink     source pixel, four raw bytes       valid & ready at clk
//  pix_out_o  source   converted pixel, bytes and count   valid & ready at clk
//  cfg_i      sink     register write (index, data)       valid & ready at clk
//
//  Throughput is one pixel per cycle while pix_out_o does not stall; the four
//  register stages (unpack, multiply, sum, pack) each take a new pixel
//  whenever they advance, and a pixel passes them in that order before
//  pix_out_o valid rises.
//  Reset clears all stage valid bits and loads both formats with RGBA.
//  A stall on pix_out_o holds every full stage; a stage takes new data as
//  soon as it is empty or its successor advances, so nothing drops or repeats.
//  cfg_i is always ready; formats travel with each pixel through the pipe.
//
module pixel_format_converter_core import pfc_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  pfc_pix_in_if.sink     pix_in_i,
  pfc_pix_out_if.source  pix_out_o,
  pfc_cfg_if.sink        cfg_i
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  fmt_t src_fmt_q, tgt_fmt_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_fmt_q <= FmtReset;
      tgt_fmt_q <= FmtReset;
    end else if (cfg_i.valid) begin
      // Keep the low format bits; drop writes beyond the register list
      if (cfg_i.index == CfgIdxSrc) begin
        src_fmt_q <= cfg_i.data[FmtW-1:0];
      end else if (cfg_i.index == CfgIdxTgt) begin
        tgt_fmt_q <= cfg_i.data[FmtW-1:0];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline control: a stage advances when it is empty or its successor does
  // --------------------------------------------------------------------------
  logic s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q;
  logic s1_en, s2_en, s3_en, s4_en;

  assign s4_en          = !s4_valid_q || pix_out_o.ready;
  assign s3_en          = !s3_valid_q || s4_en;
  assign s2_en          = !s2_valid_q || s3_en;
  assign s1_en          = !s1_valid_q || s2_en;
  assign pix_in_i.ready = s1_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else begin
      if (s1_en) s1_valid_q <= pix_in_i.valid;
      if (s2_en) s2_valid_q <= s1_valid_q;
      if (s3_en) s3_valid_q <= s2_valid_q;
      if (s4_en) s4_valid_q <= s3_valid_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: unpack the source layout into r, g, b, a
  // --------------------------------------------------------------------------
  byte_t r_d, g_d, b_d, a_d;

  always_comb begin
    r_d = '0;
    g_d = '0;
    b_d = '0;
    a_d = AlphaOpaque;
    unique case (src_fmt_q)
      FMT_R: begin
        r_d = pix_in_i.first_byte;
        g_d = pix_in_i.first_byte;
        b_d = pix_in_i.first_byte;
      end
      FMT_RA: begin
        r_d = pix_in_i.first_byte;
        g_d = pix_in_i.first_byte;
        b_d = pix_in_i.first_byte;
        a_d = pix_in_i.second_byte;
      end
      FMT_RG: begin
        r_d = pix_in_i.first_byte;
        g_d = pix_in_i.second_byte;
      end
      FMT_RGB: begin
        r_d = pix_in_i.first_byte;
        g_d = pix_in_i.second_byte;
        b_d = pix_in_i.third_byte;
      end
      FMT_RGBA: begin
        r_d = pix_in_i.first_byte;
        g_d = pix_in_i.second_byte;
        b_d = pix_in_i.third_byte;
        a_d = pix_in_i.fourth_byte;
      end
      FMT_BGR: begin
        b_d = pix_in_i.first_byte;
        g_d = pix_in_i.second_byte;
        r_d = pix_in_i.third_byte;
      end
      FMT_BGRA: begin
        b_d = pix_in_i.first_byte;
        g_d = pix_in_i.second_byte;
        r_d = pix_in_i.third_byte;
        a_d = pix_in_i.fourth_byte;
      end
      default: begin
        // Unused source code: black, opaque
      end
    endcase
  end

  byte_t s1_r_q, s1_g_q, s1_b_q, s1_a_q;
  logic  s1_src_r_q;
  fmt_t  s1_tgt_q;

  always_ff @(posedge clk_i) begin
    if (s1_en && pix_in_i.valid) begin
      s1_r_q     <= r_d;
      s1_g_q     <= g_d;
      s1_b_q     <= b_d;
      s1_a_q     <= a_d;
      s1_src_r_q <= (src_fmt_q == FMT_R);
      s1_tgt_q   <= tgt_fmt_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: weight each channel (three 24x8 products)
  // --------------------------------------------------------------------------
  prod_t s2_pr_q, s2_pg_q, s2_pb_q;
  byte_t s2_r_q, s2_g_q, s2_b_q, s2_a_q;
  logic  s2_src_r_q;
  fmt_t  s2_tgt_q;

  always_ff @(posedge clk_i) begin
    if (s2_en && s1_valid_q) begin
      s2_pr_q    <= LumaWr * prod_t'(s1_r_q);
      s2_pg_q    <= LumaWg * prod_t'(s1_g_q);
      s2_pb_q    <= LumaWb * prod_t'(s1_b_q);
      s2_r_q     <= s1_r_q;
      s2_g_q     <= s1_g_q;
      s2_b_q     <= s1_b_q;
      s2_a_q     <= s1_a_q;
      s2_src_r_q <= s1_src_r_q;
      s2_tgt_q   <= s1_tgt_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: for an R source red passes through, else sum the products and take the integer part as gray
  // --------------------------------------------------------------------------
  prod_t luma_sum;
  byte_t gray_d;

  // Weights sum to 1.0 in Q16, so the sum never exceeds 24 bits
  assign luma_sum = s2_pr_q + s2_pg_q + s2_pb_q;
  assign gray_d   = s2_src_r_q ? s2_r_q : luma_sum[ProdW-1 -: 8];

  byte_t s3_r_q, s3_g_q, s3_b_q, s3_a_q, s3_gray_q;
  fmt_t  s3_tgt_q;

  always_ff @(posedge clk_i) begin
    if (s3_en && s2_valid_q) begin
      s3_r_q    <= s2_r_q;
      s3_g_q    <= s2_g_q;
      s3_b_q    <= s2_b_q;
      s3_a_q    <= s2_a_q;
      s3_gray_q <= gray_d;
      s3_tgt_q  <= s2_tgt_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: repack in the target layout into the output register
  // --------------------------------------------------------------------------
  byte_t  o0_d, o1_d, o2_d, o3_d;
  count_t cnt_d;

  always_comb begin
    o0_d  = '0;
    o1_d  = '0;
    o2_d  = '0;
    o3_d  = '0;
    cnt_d = '0;
    unique case (s3_tgt_q)
      FMT_R: begin
        o0_d  = s3_gray_q;
        cnt_d = count_t'(1);
      end
      FMT_RA: begin
        o0_d  = s3_gray_q;
        o1_d  = s3_a_q;
        cnt_d = count_t'(2);
      end
      FMT_RG: begin
        o0_d  = s3_r_q;
        o1_d  = s3_g_q;
        cnt_d = count_t'(2);
      end
      FMT_RGB: begin
        o0_d  = s3_r_q;
        o1_d  = s3_g_q;
        o2_d  = s3_b_q;
        cnt_d = count_t'(3);
      end
      FMT_RGBA: begin
        o0_d  = s3_r_q;
        o1_d  = s3_g_q;
        o2_d  = s3_b_q;
        o3_d  = s3_a_q;
        cnt_d = count_t'(4);
      end
      FMT_BGR: begin
        o0_d  = s3_b_q;
        o1_d  = s3_g_q;
        o2_d  = s3_r_q;
        cnt_d = count_t'(3);
      end
      FMT_BGRA: begin
        o0_d  = s3_b_q;
        o1_d  = s3_g_q;
        o2_d  = s3_r_q;
        o3_d  = s3_a_q;
        cnt_d = count_t'(4);
      end
      default: begin
        // Unused target code: all zero, count zero marks it invalid
      end
    endcase
  end

  byte_t  s4_o0_q, s4_o1_q, s4_o2_q, s4_o3_q;
  count_t s4_cnt_q;

  always_ff @(posedge clk_i) begin
    if (s4_en && s3_valid_q) begin
      s4_o0_q  <= o0_d;
      s4_o1_q  <= o1_d;
      s4_o2_q  <= o2_d;
      s4_o3_q  <= o3_d;
      s4_cnt_q <= cnt_d;
    end
  end

  assign pix_out_o.valid      = s4_valid_q;
  assign pix_out_o.out_byte0  = s4_o0_q;
  assign pix_out_o.out_byte1  = s4_o1_q;
  assign pix_out_o.out_byte2  = s4_o2_q;
  assign pix_out_o.out_byte3  = s4_o3_q;
  assign pix_out_o.byte_count = s4_cnt_q;

endmodule

// ===== tb/sv/pixel_format_converter_core_tb.sv =====
// ----------------------------------------------------------------------------
// pixel_format_converter_core_tb: self-checking bench of the format converter
// Drives pixels and register writes over the valid/ready channels, predicts
// each converted pixel from the current source and target formats, and
// compares every output transaction field by field in arrival order.
// ----------------------------------------------------------------------------
module pixel_format_converter_core_tb;
  import pfc_pkg::*;

  // Format code 7 is not in the layout list; the block must still handle it
  localparam fmt_t FmtUnused = fmt_t'(7);
  // First register index past the list; writes there must be ignored
  localparam cfg_idx_t CfgIdxUnused = CfgIdxTgt + cfg_idx_t'(1);
  // Pipeline depth from the top-level header, plus some slack
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned SweepPixels  = 18;

  // Expected converted pixel: four bytes and the valid byte count
  typedef struct packed {
    byte_t  b0;
    byte_t  b1;
    byte_t  b2;
    byte_t  b3;
    count_t cnt;
  } out_pix_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  pfc_pix_in_if  pix_in ();
  pfc_pix_out_if pix_out ();
  pfc_cfg_if     cfg ();

  pixel_format_converter_core dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .pix_in_i  (pix_in),
    .pix_out_o (pix_out),
    .cfg_i     (cfg)
  );

  // Mirror of the two format registers, updated on each accepted write
  fmt_t        src_fmt;
  fmt_t        tgt_fmt;
  // Converted pixels still owed by the block, oldest first
  out_pix_t    pending_pix[$];
  out_pix_t    exp_pix;
  int unsigned fail_count;
  int unsigned sent_count;
  int unsigned checked_count;
  int unsigned write_count;
  // Random idling of the pixel source and of the output sink
  bit          gap_en;
  bit          stall_en;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Compute the converted pixel for one source pixel under the given formats
  function automatic out_pix_t convert_pixel(fmt_t src, fmt_t tgt,
                                             byte_t b0, byte_t b1,
                                             byte_t b2, byte_t b3);
    byte_t       r;
    byte_t       g;
    byte_t       b;
    byte_t       a;
    byte_t       gray;
    int unsigned luma;
    out_pix_t    res;
    r   = '0;
    g   = '0;
    b   = '0;
    a   = AlphaOpaque;
    res = '0;
    // Unpack; channels the layout lacks stay 0, alpha stays opaque
    case (src)
      FMT_R: begin
        r = b0; g = b0; b = b0;
      end
      FMT_RA: begin
        r = b0; g = b0; b = b0; a = b1;
      end
      FMT_RG: begin
        r = b0; g = b1;
      end
      FMT_RGB: begin
        r = b0; g = b1; b = b2;
      end
      FMT_RGBA: begin
        r = b0; g = b1; b = b2; a = b3;
      end
      FMT_BGR: begin
        b = b0; g = b1; r = b2;
      end
      FMT_BGRA: begin
        b = b0; g = b1; r = b2; a = b3;
      end
      default: ;
    endcase
    // Q16 luma, truncated; a one-channel source passes red through
    luma = LumaWr * r + LumaWg * g + LumaWb * b;
    gray = (src == FMT_R) ? r : byte_t'(luma >> 16);
    // Repack; an unused target gives all zeros and a count of 0
    case (tgt)
      FMT_R: begin
        res.b0 = gray; res.cnt = count_t'(1);
      end
      FMT_RA: begin
        res.b0 = gray; res.b1 = a; res.cnt = count_t'(2);
      end
      FMT_RG: begin
        res.b0 = r; res.b1 = g; res.cnt = count_t'(2);
      end
      FMT_RGB: begin
        res.b0 = r; res.b1 = g; res.b2 = b; res.cnt = count_t'(3);
      end
      FMT_RGBA: begin
        res.b0 = r; res.b1 = g; res.b2 = b; res.b3 = a; res.cnt = count_t'(4);
      end
      FMT_BGR: begin
        res.b0 = b; res.b1 = g; res.b2 = r; res.cnt = count_t'(3);
      end
      FMT_BGRA: begin
        res.b0 = b; res.b1 = g; res.b2 = r; res.b3 = a; res.cnt = count_t'(4);
      end
      default: ;
    endcase
    return res;
  endfunction

  // Bias random bytes toward the extremes now and then
  function automatic byte_t rand_byte();
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return byte_t'($urandom);
    endcase
  endfunction

  // Hold valid high until the transaction completes, then log the expectation
  task automatic send_pixel(byte_t b0, byte_t b1, byte_t b2, byte_t b3);
    @(negedge clk_i);
    while (gap_en && $urandom_range(99) < 25) begin
      pix_in.valid = 1'b0;
      @(negedge clk_i);
    end
    pix_in.valid       = 1'b1;
    pix_in.first_byte  = b0;
    pix_in.second_byte = b1;
    pix_in.third_byte  = b2;
    pix_in.fourth_byte = b3;
    do @(posedge clk_i); while (!pix_in.ready);
    pending_pix.push_back(convert_pixel(src_fmt, tgt_fmt, b0, b1, b2, b3));
    sent_count++;
  endtask

  task automatic send_rand_pixel();
    send_pixel(rand_byte(), rand_byte(), rand_byte(), rand_byte());
  endtask

  // Drop valid and wait until every owed pixel is out and the pipe is empty
  task automatic settle_pipe();
    @(negedge clk_i);
    pix_in.valid = 1'b0;
    while (pending_pix.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Write one register while the block is idle; mirror what the block keeps
  task automatic write_reg(cfg_idx_t idx, cfg_data_t data);
    settle_pipe();
    @(negedge clk_i);
    cfg.valid = 1'b1;
    cfg.index = idx;
    cfg.data  = data;
    do @(posedge clk_i); while (!cfg.ready);
    if (idx == CfgIdxSrc) begin
      src_fmt = fmt_t'(data[FmtW-1:0]);
    end else if (idx == CfgIdxTgt) begin
      tgt_fmt = fmt_t'(data[FmtW-1:0]);
    end
    write_count++;
    @(negedge clk_i);
    cfg.valid = 1'b0;
  endtask

  // Set both formats; junk in the upper data bits must be dropped
  task automatic set_formats(fmt_t src, fmt_t tgt);
    write_reg(CfgIdxSrc, {5'($urandom), src});
    write_reg(CfgIdxTgt, {5'($urandom), tgt});
  endtask

  task automatic check_field(string name, int unsigned expv, int unsigned actv);
    if (expv != actv) begin
      $display("%0t: mismatch on %s: expected 0x%0h, actual 0x%0h",
               $time, name, expv, actv);
      fail_count++;
    end
  endtask

  // Compare each output transaction with the oldest owed pixel
  always @(posedge clk_i) begin
    if (rst_ni && pix_out.valid && pix_out.ready) begin
      if (pending_pix.size() == 0) begin
        $display("%0t: output transaction with nothing owed: %h %h %h %h count %0d",
                 $time, pix_out.out_byte0, pix_out.out_byte1, pix_out.out_byte2,
                 pix_out.out_byte3, pix_out.byte_count);
        fail_count++;
      end else begin
        exp_pix = pending_pix.pop_front();
        check_field("out_byte0", exp_pix.b0, pix_out.out_byte0);
        check_field("out_byte1", exp_pix.b1, pix_out.out_byte1);
        check_field("out_byte2", exp_pix.b2, pix_out.out_byte2);
        check_field("out_byte3", exp_pix.b3, pix_out.out_byte3);
        check_field("byte_count", exp_pix.cnt, pix_out.byte_count);
        checked_count++;
      end
    end
  end

  // Stall the output at random; hold ready high while stalls are off
  always @(negedge clk_i) begin
    pix_out.ready = !(stall_en && $urandom_range(99) < 25);
  end

  // Extremes, each layout, and the gray, unused-code and ignored-write cases
  task automatic test_directed_cases();
    // Reset formats are RGBA to RGBA: plain pass-through
    send_pixel(8'h00, 8'h00, 8'h00, 8'h00);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(8'h12, 8'h34, 8'h56, 8'h78);
    set_formats(FMT_RGBA, FMT_BGRA);
    send_pixel(8'h01, 8'h80, 8'hFE, 8'h7F);
    // Luma of white must reach 255 exactly; pure primaries check each weight
    set_formats(FMT_RGB, FMT_R);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 8'h00);
    send_pixel(8'hFF, 8'h00, 8'h00, 8'hAA);
    send_pixel(8'h00, 8'hFF, 8'h00, 8'h55);
    send_pixel(8'h00, 8'h00, 8'hFF, 8'h00);
    // Gray from a one-channel source is byte0 itself
    set_formats(FMT_R, FMT_RA);
    send_pixel(8'hC3, 8'h11, 8'h22, 8'h33);
    // Gray from RA source equals byte0 too, and alpha rides along
    set_formats(FMT_RA, FMT_RA);
    send_pixel(8'h9D, 8'h40, 8'hFF, 8'hFF);
    send_pixel(8'hFF, 8'h00, 8'h00, 8'h00);
    set_formats(FMT_BGR, FMT_RG);
    send_pixel(8'h10, 8'h20, 8'h30, 8'h40);
    // Unused source code reads nothing: black, opaque, gray 0
    set_formats(FmtUnused, FMT_RGBA);
    send_pixel(8'hAB, 8'hCD, 8'hEF, 8'h12);
    write_reg(CfgIdxTgt, cfg_data_t'(FMT_RA));
    send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    // Unused target code marks the result invalid with a zero count
    set_formats(FMT_BGRA, FmtUnused);
    send_pixel(8'hFF, 8'hFF, 8'hFF, 8'hFF);
    // Writes past the register list change nothing
    set_formats(FMT_RG, FMT_RGB);
    write_reg(CfgIdxUnused, 8'hFF);
    write_reg(cfg_idx_t'(8'hFF), cfg_data_t'(FMT_R));
    send_pixel(8'h5A, 8'hA5, 8'hFF, 8'h00);
  endtask

  // Every source/target pair, including the unused code on both sides
  task automatic test_format_sweep();
    for (int s = 0; s < 8; s++) begin
      for (int t = 0; t < 8; t++) begin
        set_formats(fmt_t'(s), fmt_t'(t));
        repeat (SweepPixels) send_rand_pixel();
      end
    end
  endtask

  // Random settings in short bursts, with stray writes past the list
  task automatic test_random_settings();
    repeat (30) begin
      set_formats(fmt_t'($urandom), fmt_t'($urandom));
      if ($urandom_range(2) == 0) begin
        write_reg(cfg_idx_t'($urandom_range(CfgIdxUnused, 255)), cfg_data_t'($urandom));
      end
      repeat ($urandom_range(5, 20)) send_rand_pixel();
    end
  endtask

  // Long stretch at full rate: no source gaps and no output stalls
  task automatic test_streaming();
    gap_en   = 1'b0;
    stall_en = 1'b0;
    repeat (4) begin
      set_formats(fmt_t'($urandom_range(FMT_BGRA)), fmt_t'($urandom_range(FMT_BGRA)));
      repeat (100) send_rand_pixel();
    end
    settle_pipe();
    gap_en   = 1'b1;
    stall_en = 1'b1;
  endtask

  initial begin
    rst_ni             = 1'b0;
    pix_in.valid       = 1'b0;
    pix_in.first_byte  = '0;
    pix_in.second_byte = '0;
    pix_in.third_byte  = '0;
    pix_in.fourth_byte = '0;
    pix_out.ready      = 1'b0;
    cfg.valid          = 1'b0;
    cfg.index          = '0;
    cfg.data           = '0;
    src_fmt            = FmtReset;
    tgt_fmt            = FmtReset;
    gap_en             = 1'b1;
    stall_en           = 1'b1;
    fail_count         = 0;
    sent_count         = 0;
    checked_count      = 0;
    write_count        = 0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_cases();
    test_format_sweep();
    test_random_settings();
    test_streaming();
    settle_pipe();

    $display("Converted %0d pixels (%0d checked) over %0d register writes,",
             sent_count, checked_count, write_count);
    $display("covering all source/target pairs with random gaps, stalls and full-rate bursts.");
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Give up if the run hangs on a handshake
  initial begin
    #400000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/pfc_pkg.sv
rtl/pfc_pix_in_if.sv
rtl/pfc_pix_out_if.sv
rtl/pfc_cfg_if.sv
rtl/pixel_format_converter_core.sv
tb/sv/pixel_format_converter_core_tb.sv
